FILE: rtl/aqc_pkg.sv
// Package for the autotile quarter composer: types, constants and ROM functions.
package aqc_pkg;

   localparam int MaxSlots    = 1024;
   localparam int SlotsPerRow = 64;
   localparam int SlotW       = $clog2(MaxSlots);
   localparam int CountW      = SlotW + 1;
   localparam int ColW        = (SlotsPerRow > 1) ? $clog2(SlotsPerRow) : 1;
   localparam int RowShift    = $clog2(SlotsPerRow);
   localparam int WaterDepth  = 6768;
   localparam int WallDepth   = 600;
   localparam int WaterAw     = $clog2(WaterDepth);
   localparam int WallAw      = $clog2(WallDepth);
   localparam int CacheW      = SlotW + 1;

   typedef enum logic [2:0] {
      ST_NEW     = 3'd0,
      ST_REUSED  = 3'd1,
      ST_CACHED  = 3'd2,
      ST_BADEDGE = 3'd3,
      ST_BADPAT  = 3'd4,
      ST_BADWALL = 3'd5,
      ST_OTHER   = 3'd6,
      ST_FULL    = 3'd7
   } status_type;

   // Pattern ROM: 0 means take quarter from the B edge, 4|v means A row v.
   function automatic logic [2:0] pattern_rom(input logic [5:0] pat, input logic [1:0] q);
      logic [11:0] r;
      begin
         case (pat)
            6'd0:  r = 12'o0000; 6'd1:  r = 12'o7000; 6'd2:  r = 12'o0700;
            6'd3:  r = 12'o7700; 6'd4:  r = 12'o0007; 6'd5:  r = 12'o7007;
            6'd6:  r = 12'o0707; 6'd7:  r = 12'o7707; 6'd8:  r = 12'o0070;
            6'd9:  r = 12'o7070; 6'd10: r = 12'o0770; 6'd11: r = 12'o7770;
            6'd12: r = 12'o0077; 6'd13: r = 12'o7077; 6'd14: r = 12'o0777;
            6'd15: r = 12'o7777; 6'd16: r = 12'o5050; 6'd17: r = 12'o5750;
            6'd18: r = 12'o5057; 6'd19: r = 12'o5757; 6'd20: r = 12'o6600;
            6'd21: r = 12'o6607; 6'd22: r = 12'o6670; 6'd23: r = 12'o6677;
            6'd24: r = 12'o0505; 6'd25: r = 12'o0575; 6'd26: r = 12'o7505;
            6'd27: r = 12'o7575; 6'd28: r = 12'o0066; 6'd29: r = 12'o7066;
            6'd30: r = 12'o0766; 6'd31: r = 12'o7766; 6'd32: r = 12'o5555;
            6'd33: r = 12'o6666; 6'd34: r = 12'o4650; 6'd35: r = 12'o4657;
            6'd36: r = 12'o6405; 6'd37: r = 12'o6475; 6'd38: r = 12'o0564;
            6'd39: r = 12'o7564; 6'd40: r = 12'o5046; 6'd41: r = 12'o5746;
            6'd42: r = 12'o4455; 6'd43: r = 12'o4646; 6'd44: r = 12'o5544;
            6'd45: r = 12'o6464; 6'd46: r = 12'o4444;
            default: r = 12'o0000;
         endcase
         case (q)
            2'd0:    pattern_rom = r[11:9];
            2'd1:    pattern_rom = r[8:6];
            2'd2:    pattern_rom = r[5:3];
            default: pattern_rom = r[2:0];
         endcase
      end
   endfunction

   // Wall offset ROM: two bits per coordinate, TLx highest.
   function automatic logic [15:0] offset_rom(input logic [5:0] pat);
      begin
         case (pat)
            6'd0:  offset_rom = 16'h6666; 6'd1:  offset_rom = 16'h8666;
            6'd2:  offset_rom = 16'h6866; 6'd3:  offset_rom = 16'h8866;
            6'd4:  offset_rom = 16'h6668; 6'd5:  offset_rom = 16'h8668;
            6'd6:  offset_rom = 16'h6868; 6'd7:  offset_rom = 16'h8868;
            6'd8:  offset_rom = 16'h6686; 6'd9:  offset_rom = 16'h8686;
            6'd10: offset_rom = 16'h6886; 6'd11: offset_rom = 16'h8886;
            6'd12: offset_rom = 16'h6688; 6'd13: offset_rom = 16'h8688;
            6'd14: offset_rom = 16'h6888; 6'd15: offset_rom = 16'h8888;
            6'd16: offset_rom = 16'h2222; 6'd17: offset_rom = 16'h2822;
            6'd18: offset_rom = 16'h2228; 6'd19: offset_rom = 16'h2828;
            6'd20: offset_rom = 16'h5555; 6'd21: offset_rom = 16'h5558;
            6'd22: offset_rom = 16'h5585; 6'd23: offset_rom = 16'h5588;
            6'd24: offset_rom = 16'hAAAA; 6'd25: offset_rom = 16'hAA8A;
            6'd26: offset_rom = 16'h8AAA; 6'd27: offset_rom = 16'h8A8A;
            6'd28: offset_rom = 16'h7777; 6'd29: offset_rom = 16'h8777;
            6'd30: offset_rom = 16'h7877; 6'd31: offset_rom = 16'h8877;
            6'd32: offset_rom = 16'h2A2A; 6'd33: offset_rom = 16'h5577;
            6'd34: offset_rom = 16'h1111; 6'd35: offset_rom = 16'h1118;
            6'd36: offset_rom = 16'h9999; 6'd37: offset_rom = 16'h9989;
            6'd38: offset_rom = 16'hBBBB; 6'd39: offset_rom = 16'h8BBB;
            6'd40: offset_rom = 16'h3333; 6'd41: offset_rom = 16'h3833;
            6'd42: offset_rom = 16'h1919; 6'd43: offset_rom = 16'h1133;
            6'd44: offset_rom = 16'h3B3B; 6'd45: offset_rom = 16'h99BB;
            6'd46: offset_rom = 16'h193B; 6'd47: offset_rom = 16'h6666;
            6'd48: offset_rom = 16'h6666;
            default: offset_rom = 16'h0000;
         endcase
      end
   endfunction

endpackage

FILE: rtl/aqc_ram.sv
// Generic single-port synchronous RAM with registered read.
module aqc_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

FILE: rtl/aqc_compose.sv
// Decodes a tile ID and composes its packed quarter word and cache index.
module aqc_compose (
   input  logic [12:0]                     tile_id,
   input  logic [1:0]                      frame,
   output aqc_pkg::status_type             err_status,
   output logic                            err,
   output logic                            is_wall,
   output logic [aqc_pkg::WaterAw-1:0]     water_idx,
   output logic [aqc_pkg::WallAw-1:0]      wall_idx,
   output logic [31:0]                     word
);
   import aqc_pkg::*;

   logic [1:0]  wblock;
   logic [9:0]  wrem;
   logic [4:0]  edge_i;
   logic [5:0]  pat;
   logic [9:0]  lrem;
   logic [4:0]  lblock;
   logic [4:0]  lsub;
   logic [5:0]  lpat;
   logic [31:0] water_w;
   logic [31:0] wall_w;
   logic [3:0]  bx;
   logic [3:0]  by;
   logic [15:0] offs;
   logic [2:0]  p;
   logic [1:0]  t;
   logic [3:0]  qx;
   logic [3:0]  qy;
   logic        e;

   always_comb begin
      // Block by compare; division by 50 is a reciprocal multiply by 1311/65536,
      // which is exact for every remainder below 1024.
      if (tile_id >= 13'd2000) wblock = 2'd2;
      else if (tile_id >= 13'd1000) wblock = 2'd1;
      else wblock = 2'd0;
      wrem   = 10'(tile_id - 13'(wblock) * 13'd1000);
      edge_i = 5'((21'(wrem) * 21'd1311) >> 16);
      pat    = 6'(wrem - 10'(edge_i) * 10'd50);
      lrem   = 10'(tile_id - 13'd4000);
      lblock = 5'((21'(lrem) * 21'd1311) >> 16);
      lpat   = 6'(lrem - 10'(lblock) * 10'd50);

      water_w = '0;
      for (int q = 0; q < 4; q++) begin
         t = 2'd0;
         e = edge_i[q];
         p = pattern_rom(pat, 2'(q));
         if (p == 3'd0) begin
            t  = (wblock == 2'd2) ? {1'b0, e} ^ 2'd3 : {1'b0, e};
            qx = {2'b00, frame};
            qy = 4'd4 + {2'b00, t};
         end else begin
            qx = {2'b00, frame} + ((wblock == 2'd1) ? 4'd3 : 4'd0);
            qy = {2'b00, p[1:0]};
         end
         if (edge_i != 5'd0 && pat != 6'd0 && e) begin
            t  = (wblock == 2'd2) ? 2'd2 : 2'd1;
            qx = {2'b00, frame};
            qy = 4'd4 + {2'b00, t};
         end
         water_w[31-8*q -: 8] = {qx, qy};
      end

      lsub = lblock - 5'd4;
      if (lblock < 5'd4) begin
         bx = lblock[0] ? 4'd3 : 4'd0;
         by = 4'd8 + {1'b0, lblock[1], 2'b00};
      end else begin
         bx = lblock[0] ? 4'd9 : 4'd6;
         by = {lsub[2:1], 2'b00};
      end
      offs   = offset_rom(lpat);
      wall_w = '0;
      for (int q = 0; q < 4; q++) begin
         wall_w[31-8*q -: 8] = {bx + {2'b00, offs[15-4*q -: 2]},
                                by + {2'b00, offs[13-4*q -: 2]}};
      end

      water_idx = WaterAw'(((({11'd0, frame} * 13'd3 + {11'd0, wblock}) * 13'd16
                  + {8'd0, edge_i}) * 13'd47) + {7'd0, pat});
      wall_idx  = WallAw'(10'(lblock) * 10'd50 + 10'(lpat));

      err        = 1'b0;
      err_status = ST_OTHER;
      is_wall    = 1'b0;
      word       = water_w;
      if (tile_id < 13'd3000) begin
         if (edge_i >= 5'd16) begin
            err = 1'b1; err_status = ST_BADEDGE;
         end else if (pat >= 6'd47) begin
            err = 1'b1; err_status = ST_BADPAT;
         end
      end else if (tile_id >= 13'd4000 && tile_id < 13'd5000) begin
         is_wall = 1'b1;
         word    = wall_w;
         if (lblock >= 5'd12) begin
            err = 1'b1; err_status = ST_BADWALL;
         end
      end else begin
         err = 1'b1;
      end
   end
endmodule

FILE: rtl/autotile_quarter_composer_dedup_top.sv
// Top level of the autotile quarter composer with word de-duplication.
// Usage:
// A request enters on req_valid/req_ready with req_req_type, req_tile_id and
// req_frame. A generate request composes the tile's quarter word, checks the
// per-ID cache (not for water tiles of frame 3) and on a miss searches the
// class's word store one entry per cycle, adding a new word if there is room.
// A clear request invalidates the caches and empties both stores.
// Exactly one response follows each request on rsp_valid/rsp_ready.
// Errors are answered from composition, a cache hit from the cache read, and
// a miss after the store search, whose rate is set by the single read port
// of the word store.
// A clear request walks the larger cache memory, 6768 entries, one per cycle,
// and reset starts the same pass, during which no request is taken.
// The block works on one request at a time; req_ready is high in the idle
// state. The response waits in its register while rsp_ready is low, and the
// next request may already be taken and composed in that time, but it does
// not leave composition until the response register is free.
module autotile_quarter_composer_dedup_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_req_type,
   input  logic [12:0]                  req_tile_id,
   input  logic [1:0]                   req_frame,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_status,
   output logic [9:0]                   rsp_slot_index,
   output logic [5:0]                   rsp_slot_col,
   output logic [3:0]                   rsp_slot_row,
   output logic [31:0]                  rsp_quarter_word
);
   import aqc_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_DECIDE = 7'b0000100,
      S_CREAD  = 7'b0001000,
      S_SEARCH = 7'b0010000,
      S_WRITE  = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [12:0] id_ff;
   logic [1:0]  anim_ff;
   logic        type_ff;

   status_type  c_err_status;
   logic        c_err, c_wall;
   logic [WaterAw-1:0] c_widx;
   logic [WallAw-1:0]  c_lidx;
   logic [31:0] c_word;

   aqc_compose u_compose (
      .tile_id    (id_ff),
      .frame      (anim_ff),
      .err_status (c_err_status),
      .err        (c_err),
      .is_wall    (c_wall),
      .water_idx  (c_widx),
      .wall_idx   (c_lidx),
      .word       (c_word)
   );

   logic [WaterAw-1:0] clr_ff, clr_in;
   logic [CountW-1:0]  wcnt_ff, wcnt_in, lcnt_ff, lcnt_in;
   logic [CountW-1:0]  scan_ff, scan_in;
   logic               hit_ff, hit_in;

   logic [2:0]  o_status_ff, o_status_in;
   logic [SlotW-1:0] o_slot_ff, o_slot_in;
   logic [31:0] o_word_ff, o_word_in;
   logic        o_valid_ff, o_valid_in;

   // Cache memories.
   logic               wc_we, lc_we;
   logic [WaterAw-1:0] wc_addr;
   logic [WallAw-1:0]  lc_addr;
   logic [CacheW-1:0]  wc_wd, lc_wd, wc_rd, lc_rd;
   // Word store memories.
   logic               ws_we, ls_we;
   logic [SlotW-1:0]   s_addr;
   logic [31:0]        ws_rd, ls_rd;

   aqc_ram #(.Width(CacheW), .Depth(WaterDepth)) u_water_cache (
      .clock(clock), .wr_en(wc_we), .addr(wc_addr), .wr_data(wc_wd), .rd_data(wc_rd));
   aqc_ram #(.Width(CacheW), .Depth(WallDepth)) u_wall_cache (
      .clock(clock), .wr_en(lc_we), .addr(lc_addr), .wr_data(lc_wd), .rd_data(lc_rd));
   aqc_ram #(.Width(32), .Depth(MaxSlots)) u_water_store (
      .clock(clock), .wr_en(ws_we), .addr(s_addr), .wr_data(c_word), .rd_data(ws_rd));
   aqc_ram #(.Width(32), .Depth(MaxSlots)) u_wall_store (
      .clock(clock), .wr_en(ls_we), .addr(s_addr), .wr_data(c_word), .rd_data(ls_rd));

   logic              use_cache;
   logic [CountW-1:0] cnt;
   logic [CacheW-1:0] c_rd;
   logic [31:0]       s_rd;

   assign use_cache = c_wall || (anim_ff != 2'd3);
   assign cnt       = c_wall ? lcnt_ff : wcnt_ff;
   assign c_rd      = c_wall ? lc_rd : wc_rd;
   assign s_rd      = c_wall ? ls_rd : ws_rd;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      wcnt_in     = wcnt_ff;
      lcnt_in     = lcnt_ff;
      scan_in     = scan_ff;
      hit_in      = hit_ff;
      o_status_in = o_status_ff;
      o_slot_in   = o_slot_ff;
      o_word_in   = o_word_ff;
      o_valid_in  = o_valid_ff && !rsp_ready;
      wc_we = 1'b0; lc_we = 1'b0; ws_we = 1'b0; ls_we = 1'b0;
      wc_addr = c_widx;
      lc_addr = c_lidx;
      wc_wd   = '0;
      lc_wd   = '0;
      s_addr  = scan_ff[SlotW-1:0];

      case (state_ff)
         S_CLEAR: begin
            wc_we   = 1'b1;
            lc_we   = (clr_ff < WaterAw'(WallDepth));
            wc_addr = clr_ff;
            lc_addr = clr_ff[WallAw-1:0];
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == WaterAw'(WaterDepth - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // Composition is settled; cache read is issued this cycle.
            scan_in = '0;
            hit_in  = 1'b0;
            if (!o_valid_in) begin
               if (type_ff) begin
                  o_status_in = ST_NEW; o_slot_in = '0; o_word_in = '0;
                  o_valid_in  = 1'b1;
                  wcnt_in = '0; lcnt_in = '0; clr_in = '0;
                  state_in = S_CLEAR;
               end else if (c_err) begin
                  o_status_in = c_err_status; o_slot_in = '0; o_word_in = '0;
                  o_valid_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_CREAD;
               end
            end
         end
         S_CREAD: begin
            // Cache data valid now; issue store read of entry 0.
            if (use_cache && c_rd[CacheW-1]) begin
               o_status_in = ST_CACHED; o_slot_in = c_rd[SlotW-1:0];
               o_word_in = c_word; o_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               scan_in  = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            // Store data of entry scan_ff is valid when scan_ff < cnt.
            if (scan_ff < cnt && s_rd == c_word) begin
               hit_in   = 1'b1;
               state_in = S_WRITE;
            end else if (scan_ff >= cnt) begin
               state_in = S_WRITE;
            end else begin
               scan_in = scan_ff + 1'b1;
               s_addr  = scan_in[SlotW-1:0];
            end
         end
         S_WRITE: begin
            if (hit_ff) begin
               o_status_in = ST_REUSED; o_slot_in = scan_ff[SlotW-1:0];
            end else if (cnt >= CountW'(MaxSlots)) begin
               o_status_in = ST_FULL; o_slot_in = '0;
            end else begin
               o_status_in = ST_NEW; o_slot_in = cnt[SlotW-1:0];
               s_addr = cnt[SlotW-1:0];
               ws_we  = !c_wall;
               ls_we  = c_wall;
               if (c_wall) lcnt_in = lcnt_ff + 1'b1;
               else        wcnt_in = wcnt_ff + 1'b1;
            end
            if (hit_ff || cnt < CountW'(MaxSlots)) begin
               wc_we = use_cache && !c_wall;
               lc_we = c_wall;
               wc_wd = {1'b1, o_slot_in};
               lc_wd = {1'b1, o_slot_in};
            end
            o_word_in = c_word;
            state_in  = S_OUT;
         end
         S_OUT: begin
            o_valid_in = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         wcnt_ff    <= '0;
         lcnt_ff    <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         wcnt_ff    <= wcnt_in;
         lcnt_ff    <= lcnt_in;
         o_valid_ff <= o_valid_in;
      end
      scan_ff     <= scan_in;
      hit_ff      <= hit_in;
      o_status_ff <= o_status_in;
      o_slot_ff   <= o_slot_in;
      o_word_ff   <= o_word_in;
      if (req_valid && req_ready) begin
         id_ff   <= req_tile_id;
         anim_ff <= req_frame;
         type_ff <= req_req_type;
      end
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_status       = o_status_ff;
   assign rsp_slot_index   = 10'(o_slot_ff);
   assign rsp_slot_col     = 6'(o_slot_ff % SlotsPerRow);
   assign rsp_slot_row     = 4'(o_slot_ff >> RowShift);
   assign rsp_quarter_word = o_word_ff;
endmodule

FILE: rtl/aqc_checker.sv
// Port-level checker for the composer top level, attached by bind.
module aqc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [9:0]  rsp_slot_index,
   input logic [31:0] rsp_quarter_word
);
   import aqc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quarter_word))
      else $error("response dropped or changed while stalled");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BADEDGE || rsp_status == ST_BADPAT
      || rsp_status == ST_BADWALL || rsp_status == ST_OTHER)
      |-> rsp_slot_index == 10'd0 && rsp_quarter_word == 32'd0)
      else $error("error response carries payload");
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_slot_index == 10'd0)
      else $error("full response carries a slot");
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");
endmodule

bind autotile_quarter_composer_dedup_top aqc_checker u_aqc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_slot_index(rsp_slot_index), .rsp_quarter_word(rsp_quarter_word));
